// ===== rtl/core/tree_ancestor_lca_max_edge_unit_macros.svh =====
// Assertion macros shared by the lifting engine.
`ifndef TREE_ANCESTOR_LCA_MAX_EDGE_UNIT_MACROS_SVH
`define TREE_ANCESTOR_LCA_MAX_EDGE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check that post holds in the same cycle as pre.
`define TALM_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Check that post holds in the cycle after pre.
`define TALM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define TALM_ASSERT_NOW(label, clk, rst_n, pre, post)
`define TALM_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/core/talm_pkg.sv =====
package talm_pkg;

	localparam int DEF_MAX_NODES   = 1024;
	localparam int DEF_LEVELS      = 11;
	localparam int DEF_WEIGHT_BITS = 32;

	localparam int NODE_IN_BITS = 10;
	localparam int STEP_IN_BITS = 11;
	localparam int ANS_BITS     = 11;
	localparam int PM_BITS      = 31;

	localparam logic [1:0] KIND_INSERT   = 2'd0;
	localparam logic [1:0] KIND_ANCESTOR = 2'd1;
	localparam logic [1:0] KIND_PATH     = 2'd2;

	localparam logic [ANS_BITS-1:0] ANS_NONE = '1;

	typedef enum logic [4:0] {
		OP_HOLD, OP_LOAD, OP_INS_DEP, OP_INS_ROW0, OP_INS_RD, OP_INS_WR,
		OP_CLB_RD, OP_CLB_USE, OP_KTH_FIN, OP_P_DRD, OP_P_DUSE, OP_L_CHK,
		OP_L_RD, OP_L_USE, OP_L_RD0, OP_L_FIN, OP_M_DRD, OP_M_DUSE,
		OP_M_RD, OP_M_USE, OP_BAD
	} dp_op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_I_DEP, S_I_ROW0, S_I_RD, S_I_WR, S_C_RD, S_C_USE,
		S_K_FIN, S_P_DRD, S_P_DUSE, S_L_CHK, S_L_RD, S_L_USE, S_L_RD0,
		S_L_FIN, S_M_DRD, S_M_DUSE, S_M_RD, S_M_USE, S_BAD, S_OUT
	} state_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       x_ok;
		logic       y_ok;
		logic       k_over;
		logic       same;
	} status_t;

endpackage

// ===== rtl/core/talm_ctrl.sv =====
`include "tree_ancestor_lca_max_edge_unit_macros.svh"
module talm_ctrl #(
	parameter int LEVELS = talm_pkg::DEF_LEVELS,
	parameter int LB     = $clog2(LEVELS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  talm_pkg::status_t st,
	output talm_pkg::cmd_t    cmd,
	output logic [LB-1:0]     lvl
);
	import talm_pkg::*;

	localparam logic [LB-1:0] LVL_TOP = LB'(LEVELS - 1);

	state_t        state_q, state_d;
	logic [LB-1:0] lvl_q, lvl_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lvl_q   <= '0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
		end
	end

	// next state and level counter
	always_comb begin
		state_d = state_q;
		lvl_d   = lvl_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_DISP;
			S_DISP: begin
				lvl_d = LVL_TOP;
				case (st.kind)
					KIND_INSERT:   state_d = st.x_ok ? S_I_DEP : S_IDLE;
					KIND_ANCESTOR: state_d = (st.x_ok && !st.k_over) ? S_C_RD : S_BAD;
					KIND_PATH:     state_d = (st.x_ok && st.y_ok) ? S_P_DRD : S_BAD;
					default:       state_d = S_IDLE;
				endcase
			end
			S_I_DEP:  state_d = S_I_ROW0;
			S_I_ROW0: begin
				lvl_d   = LB'(1);
				state_d = S_I_RD;
			end
			S_I_RD:   state_d = S_I_WR;
			S_I_WR: begin
				if (lvl_q == LVL_TOP) state_d = S_IDLE;
				else begin
					lvl_d   = lvl_q + LB'(1);
					state_d = S_I_RD;
				end
			end
			S_C_RD:   state_d = S_C_USE;
			S_C_USE: begin
				if (lvl_q == '0) state_d = (st.kind == KIND_PATH) ? S_L_CHK : S_K_FIN;
				else begin
					lvl_d   = lvl_q - LB'(1);
					state_d = S_C_RD;
				end
			end
			S_K_FIN:  state_d = S_OUT;
			S_P_DRD:  state_d = S_P_DUSE;
			S_P_DUSE: begin
				lvl_d   = LVL_TOP;
				state_d = S_C_RD;
			end
			S_L_CHK: begin
				lvl_d   = LVL_TOP;
				state_d = st.same ? S_M_DRD : S_L_RD;
			end
			S_L_RD:   state_d = S_L_USE;
			S_L_USE: begin
				if (lvl_q == '0) state_d = S_L_RD0;
				else begin
					lvl_d   = lvl_q - LB'(1);
					state_d = S_L_RD;
				end
			end
			S_L_RD0:  state_d = S_L_FIN;
			S_L_FIN:  state_d = S_M_DRD;
			S_M_DRD:  state_d = S_M_DUSE;
			S_M_DUSE: begin
				lvl_d   = LVL_TOP;
				state_d = S_M_RD;
			end
			S_M_RD:   state_d = S_M_USE;
			S_M_USE: begin
				if (lvl_q == '0) state_d = S_OUT;
				else begin
					lvl_d   = lvl_q - LB'(1);
					state_d = S_M_RD;
				end
			end
			S_BAD:    state_d = S_OUT;
			S_OUT:    state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// command decode
	always_comb begin
		busy   = (state_q != S_IDLE);
		done   = 1'b0;
		cmd.op = OP_HOLD;
		case (state_q)
			S_IDLE:   cmd.op = start ? OP_LOAD : OP_HOLD;
			S_I_DEP:  cmd.op = OP_INS_DEP;
			S_I_ROW0: cmd.op = OP_INS_ROW0;
			S_I_RD:   cmd.op = OP_INS_RD;
			S_I_WR:   cmd.op = OP_INS_WR;
			S_C_RD:   cmd.op = OP_CLB_RD;
			S_C_USE:  cmd.op = OP_CLB_USE;
			S_K_FIN:  cmd.op = OP_KTH_FIN;
			S_P_DRD:  cmd.op = OP_P_DRD;
			S_P_DUSE: cmd.op = OP_P_DUSE;
			S_L_CHK:  cmd.op = OP_L_CHK;
			S_L_RD:   cmd.op = OP_L_RD;
			S_L_USE:  cmd.op = OP_L_USE;
			S_L_RD0:  cmd.op = OP_L_RD0;
			S_L_FIN:  cmd.op = OP_L_FIN;
			S_M_DRD:  cmd.op = OP_M_DRD;
			S_M_DUSE: cmd.op = OP_M_DUSE;
			S_M_RD:   cmd.op = OP_M_RD;
			S_M_USE:  cmd.op = OP_M_USE;
			S_BAD:    cmd.op = OP_BAD;
			S_OUT:    done   = 1'b1;
			default:  cmd.op = OP_HOLD;
		endcase
	end

	assign lvl = lvl_q;

	`TALM_ASSERT_NEXT(a_done_frees, clk, arst_n, done, !busy)
	`TALM_ASSERT_NEXT(a_start_takes, clk, arst_n, start && !busy, busy)
	`TALM_ASSERT_NOW(a_done_busy, clk, arst_n, done, busy && cmd.op == OP_HOLD)
	`TALM_ASSERT_NOW(a_lvl_range, clk, arst_n, busy, lvl_q <= LVL_TOP)
endmodule

// ===== rtl/core/talm_dp.sv =====
module talm_dp #(
	parameter int MAX_NODES   = talm_pkg::DEF_MAX_NODES,
	parameter int LEVELS      = talm_pkg::DEF_LEVELS,
	parameter int WEIGHT_BITS = talm_pkg::DEF_WEIGHT_BITS,
	parameter int LB          = $clog2(LEVELS)
) (
	input  logic                                clk,
	input  talm_pkg::cmd_t                      cmd,
	input  logic [LB-1:0]                       lvl,
	output talm_pkg::status_t                   st,
	input  logic [1:0]                          kind,
	input  logic [talm_pkg::NODE_IN_BITS-1:0]   node,
	input  logic [talm_pkg::NODE_IN_BITS-1:0]   other_node,
	input  logic signed [talm_pkg::ANS_BITS-1:0] parent,
	input  logic signed [31:0]                  weight,
	input  logic [talm_pkg::STEP_IN_BITS-1:0]   steps,
	output logic signed [talm_pkg::ANS_BITS-1:0] answer_node,
	output logic [talm_pkg::PM_BITS-1:0]        path_max
);
	import talm_pkg::*;

	localparam int NB   = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
	localparam int WB   = WEIGHT_BITS;
	localparam int RW   = NB + 1 + WB;
	localparam int ROWS = LEVELS * MAX_NODES;
	localparam int AW   = $clog2(ROWS);
	localparam int WD   = ((NB > LEVELS) ? NB : LEVELS) + 1;
	localparam logic [16:0] MAXN = 17'(MAX_NODES);
	localparam logic [NB:0] NONE = {1'b1, {NB{1'b0}}};

	logic [NB-1:0] dmem [MAX_NODES];
	logic [RW-1:0] rmem [ROWS];

	logic [NB-1:0] dA, dB, daA, daB, dwd;
	logic [RW-1:0] rA, rB, rwd;
	logic [AW-1:0] raA, raB, rwa;
	logic          dwe, rwe;

	logic [1:0]           kind_q;
	logic                 x_ok_q, y_ok_q, p_ok_q, k_over_q;
	logic [NB-1:0]        x_q, y_q, p_q, dl_q;
	logic [LEVELS-1:0]    k_q;
	logic signed [WB-1:0] w_q, m_q, best_q;
	logic [NB:0]          v_q, u_q, lca_q;
	logic [ANS_BITS-1:0]  ans_q;
	logic [PM_BITS-1:0]   pm_q;

	function automatic logic [AW-1:0] row_addr(input logic [LB-1:0] l,
		input logic [NB-1:0] n);
		return AW'(l) * AW'(MAX_NODES) + AW'(n);
	endfunction

	function automatic logic [ANS_BITS-1:0] to_ans(input logic [NB:0] a);
		return a[NB] ? ANS_NONE : ANS_BITS'(a[NB-1:0]);
	endfunction

	logic [NB:0]          rA_anc, rB_anc, av, au;
	logic signed [WB-1:0] rA_w, rB_w, o_w, m_n, best1, best2;
	logic [NB:0]          dinc;
	logic [NB-1:0]        dsat;
	logic [WD-1:0]        step, rhs;
	logic                 cx, cy;

	assign rA_anc = rA[RW-1 -: NB+1];
	assign rB_anc = rB[RW-1 -: NB+1];
	assign rA_w   = rA[WB-1:0];
	assign rB_w   = rB[WB-1:0];
	assign av     = v_q[NB] ? NONE : rA_anc;
	assign au     = u_q[NB] ? NONE : rB_anc;

	// insert arithmetic
	assign dinc = {1'b0, dA} + (NB+1)'(1);
	assign dsat = (dinc > (NB+1)'(MAX_NODES - 1)) ? NB'(MAX_NODES - 1) : dinc[NB-1:0];
	assign o_w  = v_q[NB] ? '0 : rA_w;
	assign m_n  = (o_w > m_q) ? o_w : m_q;

	// path maximum climb tests
	assign step  = WD'(1) << lvl;
	assign rhs   = lca_q[NB] ? (step - WD'(1)) : (WD'(dl_q) + step);
	assign cx    = !v_q[NB] && (WD'(dA) >= rhs);
	assign cy    = !u_q[NB] && (WD'(dB) >= rhs);
	assign best1 = (cx && (rA_w > best_q)) ? rA_w : best_q;
	assign best2 = (cy && (rB_w > best1)) ? rB_w : best1;

	// read and write ports
	always_comb begin
		daA = x_q;
		daB = y_q;
		raA = row_addr(lvl, v_q[NB-1:0]);
		raB = row_addr(lvl, u_q[NB-1:0]);
		case (cmd.op)
			OP_INS_DEP: daA = p_q;
			OP_M_DRD:   daA = lca_q[NB-1:0];
			OP_M_RD: begin
				daA = v_q[NB-1:0];
				daB = u_q[NB-1:0];
			end
			OP_INS_RD:  raA = row_addr(lvl - LB'(1), v_q[NB-1:0]);
			OP_L_RD0:   raA = row_addr('0, v_q[NB-1:0]);
			default:    daA = x_q;
		endcase
	end

	assign dwe = (cmd.op == OP_INS_ROW0);
	assign dwd = p_ok_q ? dsat : '0;
	assign rwe = (cmd.op == OP_INS_ROW0) || (cmd.op == OP_INS_WR);
	assign rwa = row_addr((cmd.op == OP_INS_ROW0) ? '0 : lvl, x_q);
	assign rwd = (cmd.op == OP_INS_ROW0) ?
		{!p_ok_q, p_ok_q ? p_q : NB'(0), p_ok_q ? w_q : WB'(0)} : {av, m_n};

	always_ff @(posedge clk) begin
		if (dwe) dmem[x_q] <= dwd;
		if (rwe) rmem[rwa] <= rwd;
		dA <= dmem[daA];
		dB <= dmem[daB];
		rA <= rmem[raA];
		rB <= rmem[raB];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				kind_q   <= kind;
				x_q      <= NB'(node);
				y_q      <= NB'(other_node);
				p_q      <= NB'(parent[ANS_BITS-2:0]);
				x_ok_q   <= (17'(node) < MAXN);
				y_ok_q   <= (17'(other_node) < MAXN);
				p_ok_q   <= !parent[ANS_BITS-1] && (17'(parent[ANS_BITS-2:0]) < MAXN);
				k_over_q <= (LEVELS < STEP_IN_BITS) && ((steps >> LEVELS) != '0);
				k_q      <= LEVELS'(steps);
				w_q      <= weight[WB-1:0];
				v_q      <= {1'b0, NB'(node)};
			end
			OP_INS_ROW0: begin
				v_q <= p_ok_q ? {1'b0, p_q} : NONE;
				m_q <= p_ok_q ? w_q : '0;
			end
			OP_INS_WR: begin
				v_q <= av;
				m_q <= m_n;
			end
			OP_CLB_USE: if (k_q[lvl]) v_q <= av;
			OP_KTH_FIN: begin
				ans_q <= to_ans(v_q);
				pm_q  <= '0;
			end
			OP_P_DUSE: begin
				if (dA < dB) begin
					v_q <= {1'b0, y_q};
					u_q <= {1'b0, x_q};
					k_q <= LEVELS'(dB - dA);
				end else begin
					v_q <= {1'b0, x_q};
					u_q <= {1'b0, y_q};
					k_q <= LEVELS'(dA - dB);
				end
			end
			OP_L_CHK: lca_q <= v_q;
			OP_L_USE: if (av != au) begin
				v_q <= av;
				u_q <= au;
			end
			OP_L_FIN: lca_q <= av;
			OP_M_DUSE: begin
				dl_q   <= dA;
				v_q    <= {1'b0, x_q};
				u_q    <= {1'b0, y_q};
				best_q <= '0;
			end
			OP_M_USE: begin
				if (cx) v_q <= rA_anc;
				if (cy) u_q <= rB_anc;
				best_q <= best2;
				ans_q  <= to_ans(lca_q);
				pm_q   <= PM_BITS'($unsigned(best2));
			end
			OP_BAD: begin
				ans_q <= ANS_NONE;
				pm_q  <= '0;
			end
			default: ans_q <= ans_q;
		endcase
	end

	assign st.kind   = kind_q;
	assign st.x_ok   = x_ok_q;
	assign st.y_ok   = y_ok_q;
	assign st.k_over = k_over_q;
	assign st.same   = (v_q == u_q);

	assign answer_node = ans_q;
	assign path_max    = pm_q;
endmodule

// ===== rtl/core/tree_ancestor_lca_max_edge_unit.sv =====
// Channel   Ports                                          Handshake
// command   kind node other_node parent weight steps       start, taken when busy is low
// result    answer_node path_max                           done, one-cycle strobe
//
// Insert: one row read and one row write per level above zero; no result word.
// Ancestor and path queries end with a done strobe; a path query skips the walk to the
// common ancestor when the deeper node climbs onto the other. Every walk is set by the
// dependent reads of the row memory, a read issue and a use per level.
// Reset clears the controller only; the tables hold garbage until rows are written.
// The receiver cannot stall: done is high for one cycle and busy drops after it.
module tree_ancestor_lca_max_edge_unit #(
	parameter int MAX_NODES   = talm_pkg::DEF_MAX_NODES,
	parameter int LEVELS      = talm_pkg::DEF_LEVELS,
	parameter int WEIGHT_BITS = talm_pkg::DEF_WEIGHT_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           kind,
	input  logic [talm_pkg::NODE_IN_BITS-1:0]    node,
	input  logic [talm_pkg::NODE_IN_BITS-1:0]    other_node,
	input  logic signed [talm_pkg::ANS_BITS-1:0] parent,
	input  logic signed [31:0]                   weight,
	input  logic [talm_pkg::STEP_IN_BITS-1:0]    steps,
	output logic                                 done,
	output logic signed [talm_pkg::ANS_BITS-1:0] answer_node,
	output logic [talm_pkg::PM_BITS-1:0]         path_max
);
	import talm_pkg::*;

	localparam int LB = $clog2(LEVELS);

	cmd_t          cmd;
	status_t       st;
	logic [LB-1:0] lvl;

	// sequencer: walks levels, one read issue and one use per step
	talm_ctrl #(
		.LEVELS (LEVELS),
		.LB     (LB)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.st     (st),
		.cmd    (cmd),
		.lvl    (lvl)
	);

	// tables, walk registers and result word
	talm_dp #(
		.MAX_NODES   (MAX_NODES),
		.LEVELS      (LEVELS),
		.WEIGHT_BITS (WEIGHT_BITS),
		.LB          (LB)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.lvl         (lvl),
		.st          (st),
		.kind        (kind),
		.node        (node),
		.other_node  (other_node),
		.parent      (parent),
		.weight      (weight),
		.steps       (steps),
		.answer_node (answer_node),
		.path_max    (path_max)
	);
endmodule
